// ===== src/lpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants for the nine-bit serial LCD pixel packer.
// ----------------------------------------------------------------------------
package lpp_pkg;

	localparam logic [1:0] OP_CMD   = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_PIXEL = 2'd2;

	localparam logic MODE_RGB565 = 1'b0;
	localparam logic MODE_RGB444 = 1'b1;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned BITCNT_W = 4;
	localparam logic [BITCNT_W-1:0] LAST_BIT_IDX = 4'd8;

	// One queued job: up to three bytes, oldest byte in the top bits.
	typedef struct packed {
		logic [1:0]  nwords;
		logic        flag0;
		logic [23:0] bytes;
	} job_t;

endpackage

// ===== src/lpp_front.sv =====
// ----------------------------------------------------------------------------
// lpp_front
// Accepts items, holds the pixel mode and the RGB444 half pair, and turns each
// command, data or pixel item into a byte job for the queue (others dropped).
// ----------------------------------------------------------------------------
module lpp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_mode_we,
	input  logic             pixel_mode,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       opcode,
	input  logic [7:0]       byte_value,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	input  logic             q_full,
	output logic             q_wr_en,
	output lpp_pkg::job_t    q_wr_data
);
	import lpp_pkg::*;

	logic       mode_q;
	logic       pair_phase_q;
	logic [7:0] held_rg_q;
	logic [3:0] held_b_q;
	logic       accept;
	logic       job_vld;
	logic       hold_pixel;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		job_vld    = 1'b0;
		hold_pixel = 1'b0;
		q_wr_data  = '0;
		unique case (opcode)
			OP_CMD, OP_DATA: begin
				job_vld          = 1'b1;
				q_wr_data.nwords = 2'd1;
				q_wr_data.flag0  = opcode[0];
				q_wr_data.bytes  = {byte_value, 16'h0000};
			end
			OP_PIXEL: begin
				if (mode_q == MODE_RGB565) begin
					job_vld          = 1'b1;
					q_wr_data.nwords = 2'd2;
					q_wr_data.flag0  = 1'b1;
					q_wr_data.bytes  = {red[7:3], green[7:5], green[4:2], blue[7:3], 8'h00};
				end else if (!pair_phase_q) begin
					hold_pixel = 1'b1;
				end else begin
					job_vld          = 1'b1;
					q_wr_data.nwords = 2'd3;
					q_wr_data.flag0  = 1'b1;
					q_wr_data.bytes  = {held_rg_q, held_b_q, red[7:4], green[7:4], blue[7:4]};
				end
			end
			default: begin
				// unused opcode: dropped
			end
		endcase
	end

	assign q_wr_en = accept && job_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_RGB565;
			pair_phase_q <= 1'b0;
			held_rg_q    <= '0;
			held_b_q     <= '0;
		end else begin
			if (pixel_mode_we)
				mode_q <= pixel_mode;
			if (accept && opcode == OP_PIXEL && mode_q == MODE_RGB444) begin
				pair_phase_q <= !pair_phase_q;
				if (hold_pixel) begin
					held_rg_q <= {red[7:4], green[7:4]};
					held_b_q  <= blue[7:4];
				end
			end
		end
	end

endmodule

// ===== src/lpp_queue.sv =====
// ----------------------------------------------------------------------------
// lpp_queue
// Short job queue between the front end and the serializer.
// ----------------------------------------------------------------------------
module lpp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  lpp_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output lpp_pkg::job_t rd_data,
	output logic          not_empty
);
	import lpp_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QDEPTH);
	assign not_empty = count_q != '0;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full && !rd_en))
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> not_empty)
		else $error("job queue read while empty");
`endif

endmodule

// ===== src/lpp_back.sv =====
// ----------------------------------------------------------------------------
// lpp_back
// Serializer: takes byte jobs from the queue and shifts out nine-bit words
// (flag, then the byte MSB first) into a one-entry output register.
// ----------------------------------------------------------------------------
module lpp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  lpp_pkg::job_t q_rd_data,
	output logic          q_rd_en,
	output logic          serial_bit,
	output logic          word_start,
	output logic          last_bit,
	output logic          empty,
	input  logic          pop
);
	import lpp_pkg::*;

	logic                active_q;
	logic [23:0]         data_q;
	logic                flag_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [1:0]          words_left_q;
	logic                out_vld_q;
	logic                out_bit_q;
	logic                out_ws_q;
	logic                out_last_q;

	logic adv;
	logic word_last;
	logic job_last;
	logic load;
	logic nxt_bit;

	assign adv       = active_q && (!out_vld_q || pop);
	assign word_last = bit_cnt_q == LAST_BIT_IDX;
	assign job_last  = word_last && words_left_q == 2'd1;
	assign load      = q_not_empty && (!active_q || (adv && job_last));
	assign nxt_bit   = (bit_cnt_q == '0) ? flag_q : data_q[23];
	assign q_rd_en   = load;

	assign serial_bit = out_bit_q;
	assign word_start = out_ws_q;
	assign last_bit   = out_last_q;
	assign empty      = !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			bit_cnt_q    <= '0;
			words_left_q <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (adv)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;

			if (load) begin
				active_q     <= 1'b1;
				bit_cnt_q    <= '0;
				words_left_q <= q_rd_data.nwords;
			end else if (adv) begin
				if (job_last) begin
					active_q <= 1'b0;
				end else if (word_last) begin
					bit_cnt_q    <= '0;
					words_left_q <= words_left_q - 2'd1;
				end else begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_bit_q  <= nxt_bit;
			out_ws_q   <= bit_cnt_q == '0;
			out_last_q <= job_last;
		end
		if (load) begin
			data_q <= q_rd_data.bytes;
			flag_q <= q_rd_data.flag0;
		end else if (adv) begin
			if (word_last)
				flag_q <= 1'b1;
			// flag bit does not consume a data bit
			if (bit_cnt_q != '0)
				data_q <= {data_q[22:0], 1'b0};
		end
	end

`ifndef SYNTHESIS
	a_ws_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(word_start && last_bit))
		else $error("word start and last bit on the same transfer");

	a_words_left: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (words_left_q != 2'd0 && bit_cnt_q <= LAST_BIT_IDX))
		else $error("serializer counters out of range");

	a_load_active: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> active_q)
		else $error("job load did not start the serializer");
`endif

endmodule

// ===== src/lcd_pixel_pack_9bit_serializer_top.sv =====
// ----------------------------------------------------------------------------
// lcd_pixel_pack_9bit_serializer_top
// Packs command bytes, data bytes and RGB pixels into a nine-bit serial stream.
// ----------------------------------------------------------------------------
// Input channel: push/full with opcode, byte_value, red, green, blue. An item
// transfers on a clock edge with push high and full low.
// Output channel: empty/pop; one result per serial bit (serial_bit,
// word_start, last_bit). A result transfers on an edge with pop high and
// empty low; last_bit marks the final bit of an item.
// pixel_mode is written by pixel_mode_we; the user must do so only while the
// block is idle, which it does not enforce (0 RGB565, 1 RGB444 pixel pairs).
// An item's bits pass the job queue, the serializer and the output register.
// The serializer gives one bit per cycle unless the output register holds an
// unpopped bit; an item is 9 (byte), 18 (RGB565 pixel) or 27 (completed RGB444
// pair) bits; a two-entry job queue lets the next items transfer while the
// serializer is busy, and full rises once both entries are taken.
// Reset clears the mode to RGB565, drops any held pixel and empties the queue
// and output register. When pop stays low the output bit holds, the
// serializer stops, and the queue fills until full is raised.
// ----------------------------------------------------------------------------
module lcd_pixel_pack_9bit_serializer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_mode_we,
	input  logic       pixel_mode,
	input  logic       push,
	output logic       full,
	input  logic [1:0] opcode,
	input  logic [7:0] byte_value,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       empty,
	input  logic       pop,
	output logic       serial_bit,
	output logic       word_start,
	output logic       last_bit
);
	import lpp_pkg::*;

	job_t wr_job;
	job_t rd_job;
	logic q_wr_en;
	logic q_full;
	logic q_rd_en;
	logic q_not_empty;

	lpp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixel_mode_we (pixel_mode_we),
		.pixel_mode    (pixel_mode),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.byte_value    (byte_value),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.q_full        (q_full),
		.q_wr_en       (q_wr_en),
		.q_wr_data     (wr_job)
	);

	lpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_wr_en),
		.wr_data   (wr_job),
		.full      (q_full),
		.rd_en     (q_rd_en),
		.rd_data   (rd_job),
		.not_empty (q_not_empty)
	);

	lpp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_rd_data   (rd_job),
		.q_rd_en     (q_rd_en),
		.serial_bit  (serial_bit),
		.word_start  (word_start),
		.last_bit    (last_bit),
		.empty       (empty),
		.pop         (pop)
	);

endmodule
